// ===== rtl/loop_wavelet_lifting_unit_defines.svh =====
// Assertion helpers shared by the checker files.
`ifndef LOOP_WAVELET_LIFTING_UNIT_DEFINES_SVH
`define LOOP_WAVELET_LIFTING_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LWL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent ends.
`define LWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lwl_pkg.sv =====
package lwl_pkg;

  // Field widths
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned VLC_W  = 5;
  localparam int unsigned WGT_W  = 18;
  localparam int unsigned COEF_W = 31;

  // Fraction bits of the coefficient formats
  localparam int unsigned CQ = 24;
  localparam int unsigned WQ = 16;

  // Angle constants in Q30
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 2 * PI_Q30;
  localparam longint HALF_PI_Q30 = PI_Q30 / 2;

  // Lifting V mask coefficients in Q24
  localparam logic signed [CQ:0] C14 = -25'sd8813676;
  localparam logic signed [CQ:0] C23 = 25'sd3172035;

  // Saturation limits
  localparam logic [VAL_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_LIFT1 = 3'd0,
    OP_LIFT2 = 3'd1,
    OP_LIFT3 = 3'd2,
    OP_SCALE = 3'd3,
    OP_LIFT4 = 3'd4,
    OP_LIFT5 = 3'd5,
    OP_LIFT6 = 3'd6
  } lwl_op_e;

  // One item held in the input register
  typedef struct packed {
    lwl_op_e           op;
    logic              inverse;
    logic [VAL_W-1:0]  target;
    logic [VAL_W-1:0]  nb1;
    logic [VAL_W-1:0]  nb2;
    logic [VAL_W-1:0]  nb3;
    logic [VAL_W-1:0]  nb4;
    logic [WGT_W-1:0]  weight;
    logic [COEF_W-1:0] coef;
    logic              bypass;
  } lwl_item_t;

  // One result item
  typedef struct packed {
    logic [VAL_W-1:0] out0;
    logic [VAL_W-1:0] out1;
    logic [VAL_W-1:0] out2;
    logic [VAL_W-1:0] out3;
    logic             error;
  } lwl_res_t;

  // Round to nearest, ties toward plus infinity, by 2^k
  function automatic longint lwl_rnd(input longint x, input int k);
    longint y;
    y = x + (64'sd1 <<< (k - 1));
    return y >>> k;
  endfunction

endpackage

// ===== rtl/lwl_if.sv =====
// Input item channel
interface lwl_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          op;
  logic                inverse;
  logic signed [31:0]  target;
  logic signed [31:0]  nb1;
  logic signed [31:0]  nb2;
  logic signed [31:0]  nb3;
  logic signed [31:0]  nb4;
  logic [4:0]          valence;
  logic signed [17:0]  weight;
  logic                last;

  modport source (
    output valid, op, inverse, target, nb1, nb2, nb3, nb4, valence, weight, last,
    input  ready
  );
  modport sink (
    input  valid, op, inverse, target, nb1, nb2, nb3, nb4, valence, weight, last,
    output ready
  );
endinterface

// Result item channel
interface lwl_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  out0;
  logic signed [31:0]  out1;
  logic signed [31:0]  out2;
  logic signed [31:0]  out3;
  logic                error;

  modport source (
    output valid, out0, out1, out2, out3, error,
    input  ready
  );
  modport sink (
    input  valid, out0, out1, out2, out3, error,
    output ready
  );
endinterface

// ===== rtl/loop_wavelet_lifting_unit.sv =====
// Lifting unit for the lifted Loop mesh wavelet, one Q15.16 coordinate
// component per item. It takes one item per clock unless back-pressure holds
// the input, and each result passes through the input register, a
// combinational multiply, round and saturate stage, and the result register.
// Ring neighbours (lift3 with last low) and op code seven return nothing; the
// ring sum, count and overflow flag are folded in at the input transfer, so a
// ring item can follow its predecessor in the next cycle. Valence factors come
// from a constant table built at elaboration for valences up to the larger of
// 31 and MAX_VALENCE. Back-pressure on the output holds the result register
// and then the input register before ready drops.
module loop_wavelet_lifting_unit import lwl_pkg::*; #(
  parameter int unsigned MAX_VALENCE = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lwl_in_if.sink    in_i,
  lwl_out_if.source out_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_VALENCE + 1);
  localparam int unsigned SUM_W  = VAL_W + CNT_W;
  localparam int unsigned ROM_N  = (MAX_VALENCE > 31) ? MAX_VALENCE : 31;
  localparam int unsigned ROM_AW = $clog2(ROM_N + 1);

  lwl_op_e                 in_op;
  logic                    in_xfer;
  logic                    has_result;
  logic                    out_free;
  logic                    s1_free;
  logic                    ring_acc;
  logic signed [SUM_W-1:0] ring_sum;
  logic [CNT_W-1:0]        ring_count;
  logic                    ring_ovf;
  logic [ROM_AW-1:0]       rom_addr;
  logic [COEF_W-1:0]       rom_fwd, rom_ivs, rom_dlt;
  lwl_item_t               item_d;
  lwl_res_t                alu_res;

  logic                    s1_valid_q;
  lwl_item_t               s1_item_q;
  logic signed [SUM_W-1:0] s1_sum_q;
  logic                    out_valid_q;
  lwl_res_t                res_q;

  // Handshake: input waits only when both registers are full and stalled
  assign out_free   = ~out_valid_q | out_o.ready;
  assign s1_free    = ~s1_valid_q | out_free;
  assign in_i.ready = s1_free;
  assign in_xfer    = in_i.valid & s1_free;
  assign in_op      = lwl_op_e'(in_i.op);
  assign ring_acc   = in_xfer & (in_op == OP_LIFT3);

  // Decide whether the item gives a result
  always_comb begin
    case (in_op)
      OP_LIFT1, OP_LIFT2, OP_SCALE, OP_LIFT4, OP_LIFT5, OP_LIFT6: has_result = 1'b1;
      OP_LIFT3: has_result = in_i.last;
      default:  has_result = 1'b0;
    endcase
  end

  lwl_ring #(
    .MAX_VALENCE (MAX_VALENCE),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (ring_acc),
    .last_i  (in_i.last),
    .nb1_i   (in_i.nb1),
    .sum_o   (ring_sum),
    .count_o (ring_count),
    .ovf_o   (ring_ovf)
  );

  // Ring items look up by count, scaling by valence
  assign rom_addr = (in_op == OP_LIFT3) ? ROM_AW'(ring_count) : ROM_AW'(in_i.valence);

  lwl_rom #(
    .ROM_N (ROM_N),
    .AW    (ROM_AW)
  ) u_rom (
    .addr_i (rom_addr),
    .fwd_o  (rom_fwd),
    .ivs_o  (rom_ivs),
    .dlt_o  (rom_dlt)
  );

  // Assemble the item for the input register
  always_comb begin
    item_d.op      = in_op;
    item_d.inverse = in_i.inverse;
    item_d.target  = in_i.target;
    item_d.nb1     = in_i.nb1;
    item_d.nb2     = in_i.nb2;
    item_d.nb3     = in_i.nb3;
    item_d.nb4     = in_i.nb4;
    item_d.weight  = in_i.weight;
    item_d.coef    = (in_op == OP_LIFT3) ? rom_dlt : (in_i.inverse ? rom_ivs : rom_fwd);
    item_d.bypass  = ((in_op == OP_LIFT3) && (ring_ovf || ring_count == '0)) ||
                     ((in_op == OP_SCALE) && (in_i.valence == '0));
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_xfer & has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= item_d;
      s1_sum_q  <= ring_sum;
    end
  end

  lwl_alu #(
    .SUM_W (SUM_W)
  ) u_alu (
    .item_i (s1_item_q),
    .sum_i  (s1_sum_q),
    .res_o  (alu_res)
  );

  // Result register: advance when empty or taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      res_q <= alu_res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out0  = res_q.out0;
  assign out_o.out1  = res_q.out1;
  assign out_o.out2  = res_q.out2;
  assign out_o.out3  = res_q.out3;
  assign out_o.error = res_q.error;

endmodule

// ===== rtl/lwl_rom.sv =====
module lwl_rom import lwl_pkg::*; #(
  parameter int unsigned ROM_N = 31,
  parameter int unsigned AW    = $clog2(ROM_N + 1)
) (
  input  logic [AW-1:0]     addr_i,
  output logic [COEF_W-1:0] fwd_o,
  output logic [COEF_W-1:0] ivs_o,
  output logic [COEF_W-1:0] dlt_o
);

  localparam int unsigned ROM_DEPTH = 1 << AW;

  logic [COEF_W-1:0] fwd_tab [ROM_DEPTH];
  logic [COEF_W-1:0] ivs_tab [ROM_DEPTH];
  logic [COEF_W-1:0] dlt_tab [ROM_DEPTH];

  // Build each valence entry at elaboration: folded cosine series, then P and D
  for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_tab
    if (gi >= 1 && gi <= ROM_N) begin : g_entry
      localparam longint XR  = (TWO_PI_Q30 + longint'(gi / 2)) / longint'(gi);
      localparam longint XA  = (XR > PI_Q30) ? TWO_PI_Q30 - XR : XR;
      localparam bit     NEG = XA > HALF_PI_Q30;
      localparam longint XB  = NEG ? PI_Q30 - XA : XA;
      localparam longint Y2  = lwl_rnd(XB * XB, 30);
      localparam longint T0  = 64'sd1 <<< 30;
      localparam longint T1  = -(lwl_rnd(T0 * Y2, 30) / 2);
      localparam longint T2  = -(lwl_rnd(T1 * Y2, 30) / 12);
      localparam longint T3  = -(lwl_rnd(T2 * Y2, 30) / 30);
      localparam longint T4  = -(lwl_rnd(T3 * Y2, 30) / 56);
      localparam longint T5  = -(lwl_rnd(T4 * Y2, 30) / 90);
      localparam longint T6  = -(lwl_rnd(T5 * Y2, 30) / 132);
      localparam longint T7  = -(lwl_rnd(T6 * Y2, 30) / 182);
      localparam longint T8  = -(lwl_rnd(T7 * Y2, 30) / 240);
      localparam longint T9  = -(lwl_rnd(T8 * Y2, 30) / 306);
      localparam longint T10 = -(lwl_rnd(T9 * Y2, 30) / 380);
      localparam longint CS  = T0 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10;
      localparam longint CV  = NEG ? -CS : CS;
      localparam logic [63:0] AU  = 64'(64'sd1610612736 + CV);
      localparam logic [63:0] A2  = AU * AU;
      localparam logic [63:0] A38 = (A2 + (64'd1 << 25)) >> 26;
      localparam logic [63:0] P0  = (64'd8 * A38 + 64'd2) / 64'd5;
      localparam logic [63:0] PV  = (P0 == 64'd0) ? 64'd1 : P0;
      localparam logic [63:0] IVS = (PV + (64'd1 << 13)) >> 14;
      localparam logic [63:0] FWD = ((64'd1 << 62) + PV / 64'd2) / PV;
      localparam logic [63:0] ONE = 64'd1 << 38;
      localparam logic [63:0] REM = (ONE > PV) ? ONE - PV : 64'd0;
      localparam logic [63:0] DLT = (REM + 64'(gi) * (64'd1 << 13)) / (64'(gi) << 14);

      assign fwd_tab[gi] = FWD[COEF_W-1:0];
      assign ivs_tab[gi] = IVS[COEF_W-1:0];
      assign dlt_tab[gi] = DLT[COEF_W-1:0];
    end else begin : g_unused
      assign fwd_tab[gi] = '0;
      assign ivs_tab[gi] = '0;
      assign dlt_tab[gi] = '0;
    end
  end

  // Look up the addressed entry
  assign fwd_o = fwd_tab[addr_i];
  assign ivs_o = ivs_tab[addr_i];
  assign dlt_o = dlt_tab[addr_i];

endmodule

// ===== rtl/lwl_ring.sv =====
module lwl_ring import lwl_pkg::*; #(
  parameter int unsigned MAX_VALENCE = 16,
  parameter int unsigned CNT_W       = $clog2(MAX_VALENCE + 1),
  parameter int unsigned SUM_W       = VAL_W + CNT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    acc_i,
  input  logic                    last_i,
  input  logic signed [VAL_W-1:0] nb1_i,
  output logic signed [SUM_W-1:0] sum_o,
  output logic [CNT_W-1:0]        count_o,
  output logic                    ovf_o
);

  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        count_q;
  logic                    ovf_q;
  logic                    room;

  // Ring state as it stands once the current neighbour is folded in
  always_comb begin
    room    = count_q < CNT_W'(MAX_VALENCE);
    sum_o   = room ? sum_q + SUM_W'(nb1_i) : sum_q;
    count_o = room ? count_q + CNT_W'(1) : count_q;
    ovf_o   = ovf_q | ~room;
  end

  // Accumulate on each ring transfer, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (acc_i) begin
      if (last_i) begin
        sum_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_o;
        count_q <= count_o;
        ovf_q   <= ovf_o;
      end
    end
  end

endmodule

// ===== rtl/lwl_alu.sv =====
module lwl_alu import lwl_pkg::*; #(
  parameter int unsigned SUM_W = 37
) (
  input  lwl_item_t               item_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output lwl_res_t                res_o
);

  localparam int unsigned X_W = (SUM_W + 27 > 66) ? SUM_W + 27 : 66;

  typedef struct packed {
    logic             err;
    logic [VAL_W-1:0] val;
  } lane_t;

  // Form base*2^k +/- term, round by 2^k and saturate to 32 bits
  function automatic lane_t lift_lane(input logic signed [X_W-1:0] base,
                                      input logic signed [X_W-1:0] term,
                                      input logic [4:0] k,
                                      input logic add);
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] r;
    logic [X_W-VAL_W:0]    hi;
    lane_t                 l;
    x     = (base <<< k) + (add ? term : -term);
    r     = (x + (X_W'(1) <<< (k - 5'd1))) >>> k;
    hi    = r[X_W-1:VAL_W-1];
    l.err = !((&hi) || (~|hi));
    l.val = l.err ? (r[X_W-1] ? SAT_MIN : SAT_MAX) : r[VAL_W-1:0];
    return l;
  endfunction

  logic signed [VAL_W-1:0]     tg, n1, n2, n3, n4;
  logic signed [VAL_W:0]       pair;
  logic signed [VAL_W+3:0]     mask4;
  logic signed [VAL_W+CQ:0]    p14, p23;
  logic signed [VAL_W-1:0]     mul_a, mul_b;
  logic signed [2*VAL_W-1:0]   pg;
  logic signed [SUM_W+CQ:0]    pr;
  logic signed [X_W-1:0]       base0, term0;
  logic [4:0]                  k0;
  logic                        add0;
  lane_t                       lane0, lane1, lane2, lane3;
  logic                        is_l5;

  // Neighbour sums and products
  always_comb begin
    tg    = $signed(item_i.target);
    n1    = $signed(item_i.nb1);
    n2    = $signed(item_i.nb2);
    n3    = $signed(item_i.nb3);
    n4    = $signed(item_i.nb4);
    pair  = (VAL_W + 1)'(n1) + (VAL_W + 1)'(n2);
    mask4 = (VAL_W + 4)'(pair) * 3 + (VAL_W + 4)'(n3) + (VAL_W + 4)'(n4);
    p14   = tg * C14;
    p23   = tg * C23;
    mul_a = (item_i.op == OP_LIFT6) ? n1 : tg;
    mul_b = (item_i.op == OP_LIFT6) ? VAL_W'($signed(item_i.weight))
                                    : $signed({1'b0, item_i.coef});
    pg    = mul_a * mul_b;
    pr    = sum_i * $signed({1'b0, item_i.coef[CQ-1:0]});
  end

  // Pick base, term and rounding position of the main lane
  always_comb begin
    base0 = X_W'(tg);
    term0 = X_W'(pair);
    k0    = 5'd2;
    add0  = item_i.inverse;
    case (item_i.op)
      OP_LIFT1: begin
        term0 = X_W'(pair);
        k0    = 5'd2;
      end
      OP_LIFT2: begin
        term0 = X_W'(pair);
        k0    = 5'd1;
      end
      OP_LIFT3: begin
        term0 = X_W'(pr);
        k0    = 5'(CQ);
      end
      OP_SCALE: begin
        base0 = '0;
        term0 = X_W'(pg);
        k0    = 5'(CQ);
        add0  = 1'b1;
      end
      OP_LIFT4: begin
        term0 = X_W'(mask4);
        k0    = 5'd3;
      end
      OP_LIFT5: begin
        base0 = X_W'(n1);
        term0 = X_W'(p14);
        k0    = 5'(CQ);
      end
      OP_LIFT6: begin
        term0 = X_W'(pg);
        k0    = 5'(WQ);
      end
      default: begin
        base0 = X_W'(tg);
        term0 = X_W'(pair);
        k0    = 5'd2;
      end
    endcase
  end

  // Round and saturate every lane, merge the flags
  always_comb begin
    is_l5 = (item_i.op == OP_LIFT5);
    lane0 = lift_lane(base0, term0, k0, add0);
    lane1 = lift_lane(X_W'(n2), X_W'(p23), 5'(CQ), item_i.inverse);
    lane2 = lift_lane(X_W'(n3), X_W'(p23), 5'(CQ), item_i.inverse);
    lane3 = lift_lane(X_W'(n4), X_W'(p14), 5'(CQ), item_i.inverse);
    if (item_i.bypass) begin
      res_o.out0  = item_i.target;
      res_o.error = 1'b1;
    end else begin
      res_o.out0  = lane0.val;
      res_o.error = lane0.err | (is_l5 & (lane1.err | lane2.err | lane3.err));
    end
    res_o.out1 = is_l5 ? lane1.val : '0;
    res_o.out2 = is_l5 ? lane2.val : '0;
    res_o.out3 = is_l5 ? lane3.val : '0;
  end

endmodule

// ===== rtl/lwl_checker.sv =====
`include "loop_wavelet_lifting_unit_defines.svh"

module lwl_checker import lwl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [2:0]       in_op_i,
  input logic [4:0]       in_valence_i,
  input logic [VAL_W-1:0] in_target_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VAL_W-1:0] out0_i,
  input logic [VAL_W-1:0] out1_i,
  input logic [VAL_W-1:0] out2_i,
  input logic [VAL_W-1:0] out3_i,
  input logic             error_i
);

  // Input never stalls while the result register can drain
  `LWL_ASSERT_SAME(a_drain_keeps_ready, !out_valid_i || out_ready_i, in_ready_i, "input stalled while output drains")

  // Zero valence scaling passes the target through with the error flag
  `LWL_ASSERT_NEXT(a_zero_valence, in_valid_i && in_ready_i && in_op_i == OP_SCALE && in_valence_i == 5'd0 && !out_valid_i ##1 (!out_valid_i || out_ready_i), out_valid_i && error_i && out0_i == $past(in_target_i, 2) && out1_i == '0 && out2_i == '0 && out3_i == '0, "zero valence result wrong")

  // Hold a stalled result
  `LWL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out0_i) && $stable(error_i), "stalled result changed")

endmodule

bind loop_wavelet_lifting_unit lwl_checker u_lwl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .in_valence_i (in_i.valence),
  .in_target_i  (in_i.target),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out0_i       (out_o.out0),
  .out1_i       (out_o.out1),
  .out2_i       (out_o.out2),
  .out3_i       (out_o.out3),
  .error_i      (out_o.error)
);
